// ===== design/srft_pkg.sv =====
// package for the subscriber rate fan-out table
// holds request and status codes, the table entry layout and default sizes
// no dependencies
`default_nettype none

package srft_pkg;

  // default table depth
  localparam int MAX_SUBSCRIBERS_DEF = 32;

  // fixed field widths
  localparam int ID_W    = 8;
  localparam int RATE_W  = 16;
  localparam int CNT_W   = 17;
  localparam int TALLY_W = 6;

  // request codes
  localparam logic [1:0] REQ_SUBSCRIBE = 2'd0;
  localparam logic [1:0] REQ_REMOVE    = 2'd1;
  localparam logic [1:0] REQ_SWEEP     = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_SRC   = 2'd3;

  // result kinds
  localparam logic KIND_DELIVERY = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // counter value right after subscribing (-1)
  localparam logic [CNT_W-1:0] COUNT_RESTART = '1;

  // one table entry as held in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate_zero;
    logic [RATE_W-1:0] rate_one;
    logic [CNT_W-1:0]  count_zero;
    logic [CNT_W-1:0]  count_one;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic                 result_kind;
    logic [ID_W-1:0]      target_id;
    logic                 target_source;
    logic [1:0]           status;
    logic [TALLY_W-1:0]   count_zero;
    logic [TALLY_W-1:0]   count_one;
    logic                 last_result;
  } result_t;

endpackage

`default_nettype wire

// ===== design/subscriber_rate_fanout_table.sv =====
// subscriber rate fan-out table, top level
// ordered subscriber table in one synchronous memory, walked once per request
// depends on srft_pkg
//
// usage: requests arrive on the s_ channel (subscribe, remove, sweep event).
// each accepted request walks the table from entry 0 to the last used entry,
// reading one entry per cycle from the memory (registered read) while not stalled.
// a sweep event emits one delivery beat on the m_ channel per subscriber due,
// in table order; every request ends with one status beat with tlast high
// carrying the status code and the subscriber counts per source.
// s_tready is high only between requests; a new request is taken the cycle
// after the status beat has been loaded into the output register.
// when the receiver stalls, the walk holds on the entry whose delivery is
// waiting, so no beat is lost; results leave through a one-deep output
// register. reset empties the table (entry count zero) and drops any beat
// in flight; the memory contents need no clearing.
`default_nettype none

module subscriber_rate_fanout_table
  import srft_pkg::*;
#(
  parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: subscriber_id[7:0], rate_zero[23:8], rate_one[39:24],
  //        source_select[41:40], zero[47:42]
  input  wire logic [47:0] s_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: target_id[7:0], target_source[8], status[10:9],
  //        count_zero[16:11], count_one[22:17], zero[23]
  output logic [23:0]      m_tdata,
  // tuser: result_kind[0]
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int IDX_W = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int USE_W = $clog2(MAX_SUBSCRIBERS + 1);
  localparam logic [USE_W-1:0] MAX_USED = USE_W'(MAX_SUBSCRIBERS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_FINISH = 4'b0100,
    S_STATUS = 4'b1000
  } state_t;

  state_t state;

  // table memory and its ports
  entry_t            mem [MAX_SUBSCRIBERS];
  entry_t            rd_data;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // request registers
  logic [1:0]        req_q;
  logic [ID_W-1:0]   id_q;
  logic [RATE_W-1:0] rate_zero_q;
  logic [RATE_W-1:0] rate_one_q;
  logic [1:0]        src_q;

  // walk control
  logic [USE_W-1:0]  used;
  logic [USE_W-1:0]  issue_ptr;
  logic              proc_valid;
  logic [IDX_W-1:0]  proc_idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              old_nz_zero;
  logic              old_nz_one;
  logic [USE_W-1:0]  acc_zero;
  logic [USE_W-1:0]  acc_one;

  // final status of the request
  logic [1:0]        st_q;
  logic [USE_W-1:0]  tally_zero_q;
  logic [USE_W-1:0]  tally_one_q;
  logic [1:0]        st_next;
  logic [USE_W-1:0]  tally_zero_next;
  logic [USE_W-1:0]  tally_one_next;
  logic [USE_W-1:0]  used_next;

  // output register
  logic              out_valid;
  result_t           out_q;
  logic              out_free;

  // walk datapath
  logic              is_sub;
  logic              is_remove;
  logic              sweep_ok;
  logic [RATE_W-1:0] sel_rate;
  logic [CNT_W-1:0]  sel_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_new;
  logic              hit;
  logic              active;
  logic              deliver;
  logic              stall;
  logic              step;
  logic              id_match;
  logic              rm_match;
  logic              walk_done;
  logic              sub_full;
  logic [IDX_W-1:0]  sub_slot;
  entry_t            upd_entry;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.result_kind;
  assign m_tlast  = out_q.last_result;
  assign m_tdata  = {1'b0, out_q.count_one, out_q.count_zero, out_q.status,
                     out_q.target_source, out_q.target_id};
  assign out_free = !out_valid || m_tready;

  // decode of the entry under processing
  always_comb begin
    is_sub    = (req_q == REQ_SUBSCRIBE);
    is_remove = (req_q == REQ_REMOVE);
    sweep_ok  = (req_q == REQ_SWEEP) && !src_q[1];
    sel_rate  = src_q[0] ? rd_data.rate_one  : rd_data.rate_zero;
    sel_cnt   = src_q[0] ? rd_data.count_one : rd_data.count_zero;
    cnt_inc   = (sel_cnt == COUNT_RESTART) ? '0 : sel_cnt + CNT_W'(1);
    hit       = (cnt_inc == '0) || (cnt_inc == {1'b0, sel_rate});
    cnt_new   = hit ? '0 : cnt_inc;
    active    = proc_valid && sweep_ok && (sel_rate != '0);
    deliver   = active && hit;
    stall     = deliver && !out_free;
    step      = (state == S_WALK) && !stall;
    id_match  = (rd_data.id == id_q);
    rm_match  = is_remove && id_match && !found;
    rd_en     = step && (issue_ptr < used);
    walk_done = (state == S_WALK) && !proc_valid && !(issue_ptr < used);
    upd_entry = rd_data;
    if (src_q[0]) begin
      upd_entry.count_one = cnt_new;
    end else begin
      upd_entry.count_zero = cnt_new;
    end
  end

  // closing step of the request: subscribe write, counts and status
  always_comb begin
    sub_full        = (used >= MAX_USED);
    sub_slot        = found ? found_idx : used[IDX_W-1:0];
    st_next         = ST_OK;
    tally_zero_next = acc_zero;
    tally_one_next  = acc_one;
    used_next       = used;
    case (req_q)
      REQ_SUBSCRIBE: begin
        if (sub_full) begin
          st_next = ST_FULL;
        end else begin
          tally_zero_next = acc_zero - USE_W'(found && old_nz_zero)
                            + USE_W'(rate_zero_q != '0);
          tally_one_next  = acc_one - USE_W'(found && old_nz_one)
                            + USE_W'(rate_one_q != '0);
          if (!found) begin
            used_next = used + USE_W'(1);
          end
        end
      end
      REQ_REMOVE: begin
        if (!found) begin
          st_next = ST_NOT_FOUND;
        end else begin
          used_next = used - USE_W'(1);
        end
      end
      REQ_SWEEP: begin
        if (src_q[1]) begin
          st_next = ST_BAD_SRC;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // memory write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx;
    wr_data = upd_entry;
    if (step && proc_valid && is_remove && found) begin
      wr_en   = 1'b1;
      wr_addr = proc_idx - IDX_W'(1);
      wr_data = rd_data;
    end else if (step && active) begin
      wr_en   = 1'b1;
      wr_addr = proc_idx;
      wr_data = upd_entry;
    end else if ((state == S_FINISH) && is_sub && !sub_full) begin
      wr_en   = 1'b1;
      wr_addr = sub_slot;
      wr_data = '{id: id_q, rate_zero: rate_zero_q, rate_one: rate_one_q,
                  count_zero: COUNT_RESTART, count_one: COUNT_RESTART};
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[issue_ptr[IDX_W-1:0]];
      proc_idx <= issue_ptr[IDX_W-1:0];
    end
  end

  // request capture and per-entry bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      req_q       <= s_tuser;
      id_q        <= s_tdata[7:0];
      rate_zero_q <= s_tdata[23:8];
      rate_one_q  <= s_tdata[39:24];
      src_q       <= s_tdata[41:40];
      acc_zero    <= '0;
      acc_one     <= '0;
    end else if (step && proc_valid) begin
      if (!rm_match) begin
        acc_zero <= acc_zero + USE_W'(rd_data.rate_zero != '0);
        acc_one  <= acc_one + USE_W'(rd_data.rate_one != '0);
      end
      if (is_sub && id_match && !found) begin
        found_idx   <= proc_idx;
        old_nz_zero <= (rd_data.rate_zero != '0);
        old_nz_one  <= (rd_data.rate_one != '0);
      end
    end
    if (state == S_FINISH) begin
      st_q         <= st_next;
      tally_zero_q <= tally_zero_next;
      tally_one_q  <= tally_one_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      issue_ptr  <= '0;
      proc_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            issue_ptr  <= '0;
            proc_valid <= 1'b0;
            found      <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_FINISH;
          end else if (step) begin
            proc_valid <= rd_en;
            if (rd_en) begin
              issue_ptr <= issue_ptr + USE_W'(1);
            end
            if (proc_valid && (is_sub || is_remove) && id_match) begin
              found <= 1'b1;
            end
          end
        end
        S_FINISH: begin
          used  <= used_next;
          state <= S_STATUS;
        end
        S_STATUS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: deliveries during the walk, then the status beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && deliver) begin
      out_valid <= 1'b1;
    end else if ((state == S_STATUS) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && deliver) begin
      out_q <= '{result_kind: KIND_DELIVERY, target_id: rd_data.id,
                 target_source: src_q[0], status: ST_OK,
                 count_zero: '0, count_one: '0, last_result: 1'b0};
    end else if ((state == S_STATUS) && out_free) begin
      out_q <= '{result_kind: KIND_STATUS, target_id: '0,
                 target_source: 1'b0, status: st_q,
                 count_zero: TALLY_W'(tally_zero_q),
                 count_one: TALLY_W'(tally_one_q), last_result: 1'b1};
    end
  end

endmodule

`default_nettype wire
